### rtl/assert_macros.svh
// Assertion helpers for the ordered waiting queue.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant: the condition holds at every clock edge outside reset.
`define OWQ_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define OWQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OWQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/owq_pkg.sv
`timescale 1ns / 1ps
package owq_pkg;

    localparam int CMD_W      = 3;
    localparam int TAG_W      = 16;
    localparam int KEY_W      = 32;
    localparam int RANK_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int SUM_W      = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 2;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT       = 3'd0,
        CMD_REMOVE_FIRST = 3'd1,
        CMD_PEEK         = 3'd2,
        CMD_REMOVE_AT    = 3'd3,
        CMD_CLEAR        = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RULE_FIFO = 2'd0,
        RULE_LIFO = 2'd1,
        RULE_HIGH = 2'd2,
        RULE_LOW  = 2'd3
    } rule_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORDER_RULE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_PRESENT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [TAG_W-1:0]        entry_tag;
        logic signed [KEY_W-1:0] entry_key;
        logic [RANK_W-1:0]       rank;
    } owq_req_t;

    typedef struct packed {
        logic [TAG_W-1:0]        out_tag;
        logic signed [KEY_W-1:0] out_key;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      entry_count;
        logic signed [SUM_W-1:0] key_sum;
    } owq_rsp_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        rule_t                   rule;
        logic                    key_present;
        logic signed [KEY_W-1:0] key;
    } owq_ctl_t;

endpackage

### rtl/owq_if.sv
`timescale 1ns / 1ps
interface owq_req_if import owq_pkg::*; ();
    logic     valid;
    logic     ready;
    owq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface owq_rsp_if import owq_pkg::*; ();
    logic     valid;
    logic     ready;
    owq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/owq_cell.sv
`timescale 1ns / 1ps
module owq_cell import owq_pkg::*; #(
    parameter int INDEX    = 0,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int CNT_W    = 5
) (
    input  logic                    clk,
    input  owq_ctl_t                ctl,
    input  logic [TAG_BITS-1:0]     new_tag,
    input  logic [CNT_W-1:0]        occ,
    input  logic [CNT_W-1:0]        rem_pos,
    input  logic [TAG_BITS-1:0]     left_tag,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic [TAG_BITS-1:0]     right_tag,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic                    found_in,
    output logic                    found_out,
    output logic [TAG_BITS-1:0]     tag_q,
    output logic signed [KEY_W-1:0] key_q
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [TAG_BITS-1:0]     tag_reg;
    logic [TAG_BITS-1:0]     tag_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    precede;
    logic                    hit;

    // New key must stand ahead of this cell's entry.
    always_comb
    begin
        case (ctl.rule)
            RULE_LIFO: precede = 1'b1;
            RULE_HIGH: precede = ctl.key_present && (key_reg < ctl.key);
            RULE_LOW:  precede = ctl.key_present && (key_reg > ctl.key);
            default:   precede = 1'b0;
        endcase
    end

    // The first empty cell catches an insert nothing else claimed.
    assign hit       = (IDX < occ) ? precede : (IDX == occ);
    assign found_out = found_in | hit;

    always_comb
    begin
        tag_next = tag_reg;
        key_next = key_reg;
        if (ctl.ins)
        begin
            if (found_in)
            begin
                tag_next = left_tag;
                key_next = left_key;
            end
            else if (hit)
            begin
                tag_next = new_tag;
                key_next = ctl.key;
            end
        end
        else if (ctl.rem && (IDX >= rem_pos))
        begin
            tag_next = right_tag;
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        key_reg <= key_next;
    end

    assign tag_q = tag_reg;
    assign key_q = key_reg;

endmodule

### rtl/owq_row.sv
`timescale 1ns / 1ps
module owq_row import owq_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int CNT_W    = 5,
    parameter int IDX_W    = 4
) (
    input  logic                    clk,
    input  owq_ctl_t                ctl,
    input  logic [TAG_BITS-1:0]     new_tag,
    input  logic [CNT_W-1:0]        occ,
    input  logic [IDX_W-1:0]        rd_pos,
    output logic [TAG_BITS-1:0]     rd_tag,
    output logic signed [KEY_W-1:0] rd_key
);

    logic [TAG_BITS-1:0]     tag_q [DEPTH];
    logic signed [KEY_W-1:0] key_q [DEPTH];
    logic [DEPTH:0]          found;
    logic [CNT_W-1:0]        rem_pos;

    assign found[0] = 1'b0;
    assign rem_pos  = CNT_W'(rd_pos);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TAG_BITS-1:0]     l_tag;
        logic signed [KEY_W-1:0] l_key;
        logic [TAG_BITS-1:0]     r_tag;
        logic signed [KEY_W-1:0] r_key;

        if (i == 0)
        begin : g_head
            assign l_tag = '0;
            assign l_key = '0;
        end
        else
        begin : g_mid
            assign l_tag = tag_q[i-1];
            assign l_key = key_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_tag = '0;
            assign r_key = '0;
        end
        else
        begin : g_body
            assign r_tag = tag_q[i+1];
            assign r_key = key_q[i+1];
        end

        owq_cell #(
            .INDEX    (i),
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .new_tag   (new_tag),
            .occ       (occ),
            .rem_pos   (rem_pos),
            .left_tag  (l_tag),
            .left_key  (l_key),
            .right_tag (r_tag),
            .right_key (r_key),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .tag_q     (tag_q[i]),
            .key_q     (key_q[i])
        );
    end

    assign rd_tag = tag_q[rd_pos];
    assign rd_key = key_q[rd_pos];

endmodule

### rtl/ordered_waiting_queue.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                       Handshake
// req       in   cmd, entry_tag, entry_key, rank               valid/ready
// rsp       out  out_tag, out_key, status, entry_count, key_sum valid/ready
// cfg       in   cfg_addr (register index), cfg_data           cfg_we, no wait
//
// For every accepted item the cell row updates at the accept edge and the result lands
// in the output register, visible the next cycle. Sustained rate is one item per cycle
// while rsp.ready holds; the insert search ripples through the found chain.
// req is taken whenever the output register is empty or being drained.
// Reset clears the count, the key sum, the rule registers and the output valid;
// cell contents are left as they are, as no cell at or past the count is read.
module ordered_waiting_queue import owq_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    owq_req_if.sink               req,
    owq_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Configuration.
    rule_t rule_reg;
    logic  keyp_reg;

    // Queue bookkeeping.
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    // Output register.
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    owq_rsp_t rsp_data_reg;
    owq_rsp_t rsp_data_next;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic [CMP_W-1:0]        rank_w;
    logic [CMP_W-1:0]        occ_w;
    logic                    rank_ok;
    logic [IDX_W-1:0]        rd_pos;
    logic [TAG_BITS-1:0]     new_tag;
    logic [TAG_BITS-1:0]     rd_tag;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [SUM_W-1:0] new_key_ext;
    logic signed [SUM_W-1:0] rd_key_ext;
    owq_ctl_t                ctl;

    // Hold the result until taken; take a new item once the slot frees.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign full    = (occ_reg == FULL_COUNT);
    assign empty   = (occ_reg == '0);
    assign rank_w  = CMP_W'(req.data.rank);
    assign occ_w   = CMP_W'(occ_reg);
    assign rank_ok = (rank_w < occ_w);
    assign new_tag = TAG_BITS'(req.data.entry_tag);

    // Remove first reads the front cell; rank commands read the ranked cell.
    assign rd_pos = (req.data.cmd == CMD_REMOVE_FIRST) ? '0 : rank_w[IDX_W-1:0];

    assign new_key_ext = SUM_W'(req.data.entry_key);
    assign rd_key_ext  = SUM_W'(rd_key);

    always_comb
    begin
        occ_next                  = occ_reg;
        sum_next                  = sum_reg;
        ctl.ins                   = 1'b0;
        ctl.rem                   = 1'b0;
        ctl.rule                  = rule_reg;
        ctl.key_present           = keyp_reg;
        ctl.key                   = req.data.entry_key;
        rsp_data_next.out_tag     = '0;
        rsp_data_next.out_key     = '0;
        rsp_data_next.status      = ST_OK;
        case (req.data.cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    rsp_data_next.status = ST_FULL;
                end
                else
                begin
                    ctl.ins  = accept;
                    occ_next = occ_reg + CNT_W'(1);
                    sum_next = sum_reg + new_key_ext;
                end
            end
            CMD_REMOVE_FIRST:
            begin
                if (empty)
                begin
                    rsp_data_next.status = ST_NO_ENTRY;
                end
                else
                begin
                    ctl.rem               = accept;
                    occ_next              = occ_reg - CNT_W'(1);
                    sum_next              = sum_reg - rd_key_ext;
                    rsp_data_next.out_tag = TAG_W'(rd_tag);
                    rsp_data_next.out_key = rd_key;
                end
            end
            CMD_PEEK:
            begin
                if (!rank_ok)
                begin
                    rsp_data_next.status = ST_NO_ENTRY;
                end
                else
                begin
                    rsp_data_next.out_tag = TAG_W'(rd_tag);
                    rsp_data_next.out_key = rd_key;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (!rank_ok)
                begin
                    rsp_data_next.status = ST_NO_ENTRY;
                end
                else
                begin
                    ctl.rem               = accept;
                    occ_next              = occ_reg - CNT_W'(1);
                    sum_next              = sum_reg - rd_key_ext;
                    rsp_data_next.out_tag = TAG_W'(rd_tag);
                    rsp_data_next.out_key = rd_key;
                end
            end
            CMD_CLEAR:
            begin
                occ_next = '0;
                sum_next = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
        rsp_data_next.entry_count = COUNT_W'(occ_next);
        rsp_data_next.key_sum     = sum_next;
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    // Cell row: holds the entries in service order, front at cell 0.
    owq_row #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_row (
        .clk     (clk),
        .ctl     (ctl),
        .new_tag (new_tag),
        .occ     (occ_reg),
        .rd_pos  (rd_pos),
        .rd_tag  (rd_tag),
        .rd_key  (rd_key)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg <= RULE_FIFO;
            keyp_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ORDER_RULE:  rule_reg <= rule_t'(cfg_data);
                CFG_KEY_PRESENT: keyp_reg <= cfg_data[0];
                default:         keyp_reg <= keyp_reg;
            endcase
        end
    end

    // Advance count and key sum only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                occ_reg <= occ_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    `OWQ_ASSERT_ALWAYS(a_occ_bound, occ_reg <= FULL_COUNT, "occupancy above depth")
    `OWQ_ASSERT_IMPL(a_no_overrun, rsp_valid_reg && !rsp.ready, !accept,
                     "item taken over a held result")
    `OWQ_ASSERT_NEXT(a_insert_count, accept && req.data.cmd == CMD_INSERT && !full,
                     occ_reg == $past(occ_reg) + CNT_W'(1),
                     "insert did not grow the queue")
    `OWQ_ASSERT_NEXT(a_clear, accept && req.data.cmd == CMD_CLEAR,
                     occ_reg == '0 && sum_reg == '0 && rsp_valid_reg,
                     "clear left state behind")

endmodule
